// File: sv/utf8_to_ucs2_stream_decoder_assert.svh
// Assertion helpers for the UTF-8 stream decoder.
`ifndef UTF8_TO_UCS2_STREAM_DECODER_ASSERT_SVH
`define UTF8_TO_UCS2_STREAM_DECODER_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define U2S_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define U2S_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/u2s_pkg.sv
`default_nettype none

package u2s_pkg;

  // Status codes reported with each result word
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_LEAD  = 2'd1;
  localparam logic [1:0] ST_TRUNCATED = 2'd2;
  localparam logic [1:0] ST_LIMIT     = 2'd3;

  localparam logic [15:0] COUNT_MAX = 16'hffff;

  // Per-stream decoder state
  typedef struct packed {
    logic [15:0] partial;
    logic [1:0]  bytes_left;
    logic        halted;
    logic [1:0]  status;
    logic [15:0] count;
  } state_t;

  // One result word
  typedef struct packed {
    logic [15:0] unit;
    logic        unit_valid;
    logic        done;
    logic [15:0] count;
    logic [1:0]  status;
  } result_t;

  // Sequence length from a lead byte; zero marks an invalid lead
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    priority if (b[7] == 1'b0)        len = 3'd1;
    else if (b[7:5] == 3'b110)        len = 3'd2;
    else if (b[7:4] == 4'b1110)       len = 3'd3;
    else if (b[7:3] == 5'b11110)      len = 3'd4;
    else                              len = 3'd0;
    return len;
  endfunction

endpackage

`default_nettype wire

// File: sv/utf8_to_ucs2_stream_decoder.sv
// Channel  | Ports                                     | Accept
// ---------+-------------------------------------------+-----------------------
// input    | in_byte, in_last_byte                     | in_valid & in_ready
// result   | out_unit, out_unit_valid, out_done_res,   | out_valid & out_ready
//          | out_unit_count, out_status                |
// config   | cfg_wr_en, cfg_wr_data (max_units)        | cfg_wr_en
//
// One byte per cycle sustained unless a stalled result blocks it; a byte passes the
// input register, then its result word is decoded into the result register.
// The decode step and the stream-state register form a feedback loop.
// Synchronous active-low reset clears stream state and sets max_units to 65535.
// A stalled result only blocks bytes that produce a result; other bytes flow.
`default_nettype none

module utf8_to_ucs2_stream_decoder (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_byte,
  input  wire logic        in_last_byte,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_unit,
  output logic             out_unit_valid,
  output logic             out_done_res,
  output logic [15:0]      out_unit_count,
  output logic [1:0]       out_status,
  input  wire logic        cfg_wr_en,
  input  wire logic [15:0] cfg_wr_data
);
  import u2s_pkg::*;

  logic [15:0] max_units_r;
  logic        s1_valid_r;
  logic [7:0]  s1_byte_r;
  logic        s1_last_r;
  state_t      st_r;
  state_t      st_nxt;
  result_t     res;
  logic        emit;
  logic        out_free;
  logic        s1_adv;
  logic        out_valid_r;
  result_t     out_r;

  // Hold the unit limit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_units_r <= 16'hffff;
    end else if (cfg_wr_en) begin
      max_units_r <= cfg_wr_data;
    end
  end

  u2s_step u_step (
    .st        (st_r),
    .in_byte   (s1_byte_r),
    .in_last   (s1_last_r),
    .max_units (max_units_r),
    .st_nxt    (st_nxt),
    .res       (res),
    .emit      (emit)
  );

  // Advance a byte unless its result word has nowhere to go
  assign out_free = !out_valid_r || out_ready;
  assign s1_adv   = s1_valid_r && (!emit || out_free);
  assign in_ready = !s1_valid_r || s1_adv;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_byte_r <= in_byte;
      s1_last_r <= in_last_byte;
    end
  end

  // Stream state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= '0;
    end else if (s1_adv) begin
      st_r <= st_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && emit) begin
      out_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_unit       = out_r.unit;
  assign out_unit_valid = out_r.unit_valid;
  assign out_done_res   = out_r.done;
  assign out_unit_count = out_r.count;
  assign out_status     = out_r.status;

`include "utf8_to_ucs2_stream_decoder_assert.svh"

  `U2S_ASSERT_NOW(a_no_unit_only_at_end, clk, rst_n, out_valid_r && !out_r.unit_valid, out_r.done && out_r.unit == 16'd0, "result without unit must be the final word")
  `U2S_ASSERT_NOW(a_unit_counted, clk, rst_n, out_valid_r && out_r.unit_valid, out_r.count != 16'd0, "emitted unit with zero count")
  `U2S_ASSERT_NEXT(a_state_cleared, clk, rst_n, s1_adv && s1_last_r, st_r == '0, "stream state not cleared after final byte")

endmodule

`default_nettype wire

// File: sv/u2s_step.sv
`default_nettype none

module u2s_step (
  input  wire u2s_pkg::state_t  st,
  input  wire logic [7:0]       in_byte,
  input  wire logic             in_last,
  input  wire logic [15:0]      max_units,
  output u2s_pkg::state_t       st_nxt,
  output u2s_pkg::result_t      res,
  output logic                  emit
);
  import u2s_pkg::*;

  logic        count_mode;
  logic [2:0]  len;
  logic [15:0] gathered;
  logic [1:0]  left_dec;
  logic [15:0] bumped;
  logic        valid;
  logic [15:0] u;
  state_t      s;

  assign count_mode = (max_units == 16'd0);
  assign len        = lead_length(in_byte);
  assign gathered   = {st.partial[9:0], in_byte[5:0]};
  assign left_dec   = st.bytes_left - 2'd1;
  assign bumped     = (st.count != COUNT_MAX) ? st.count + 16'd1 : st.count;

  // Decode one byte against the current stream state
  always_comb begin
    s     = st;
    valid = 1'b0;
    u     = 16'd0;
    if (!st.halted) begin
      if (st.bytes_left != 2'd0) begin
        // continuation: shift in six payload bits
        s.partial    = gathered;
        s.bytes_left = left_dec;
        if (left_dec == 2'd0) begin
          if (!count_mode) begin
            valid   = 1'b1;
            u       = gathered;
            s.count = bumped;
          end
        end else if (in_last) begin
          s.status = ST_TRUNCATED;
        end
      end else begin
        // lead byte
        priority if (len == 3'd0) begin
          s.halted = 1'b1;
          s.status = ST_BAD_LEAD;
        end else if (count_mode) begin
          s.count      = bumped;
          s.partial    = 16'd0;
          s.bytes_left = 2'(len - 3'd1);
          if (in_last && len > 3'd1) s.status = ST_TRUNCATED;
        end else if (st.count >= max_units) begin
          s.halted = 1'b1;
          s.status = ST_LIMIT;
        end else if (len == 3'd1) begin
          valid   = 1'b1;
          u       = {8'd0, in_byte};
          s.count = bumped;
        end else if (in_last) begin
          s.halted = 1'b1;
          s.status = ST_TRUNCATED;
        end else begin
          unique case (len)
            3'd2:    s.partial = {11'd0, in_byte[4:0]};
            3'd3:    s.partial = {12'd0, in_byte[3:0]};
            default: s.partial = {13'd0, in_byte[2:0]};
          endcase
          s.bytes_left = 2'(len - 3'd1);
        end
      end
    end
  end

  // Build the result word and clear state at stream end
  always_comb begin
    res.unit       = u;
    res.unit_valid = valid;
    res.done       = in_last;
    res.count      = s.count;
    res.status     = s.status;
    emit           = valid || in_last;
    st_nxt         = in_last ? '0 : s;
  end

endmodule

`default_nettype wire

// File: verif/utf8_to_ucs2_stream_decoder_test.sv
`default_nettype none

module utf8_to_ucs2_stream_decoder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import u2s_pkg::*;

  localparam int DIRECTED_ROWS = 32;
  localparam int RANDOM_BYTES  = 1520;
  localparam int PHASE_BYTES   = 155;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 4;
  localparam int DRAIN_LIMIT   = 5000;

  typedef enum logic [1:0] {ROW_BYTE, ROW_CHECKED, ROW_LIMIT} row_kind_t;

  // One directed row: a source byte, or a new unit limit in value
  typedef struct packed {
    row_kind_t   kind;
    logic [15:0] value;
    logic        last;
    result_t     want;
  } step_t;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  in_byte;
  logic        in_last_byte;
  logic        out_valid;
  logic        out_ready;
  logic [15:0] out_unit;
  logic        out_unit_valid;
  logic        out_done_res;
  logic [15:0] out_unit_count;
  logic [1:0]  out_status;
  logic        cfg_wr_en;
  logic [15:0] cfg_wr_data;

  // Decoder image kept by the testbench
  state_t      decoder;
  logic [15:0] unit_limit;
  result_t     unit_words_due[$];

  int   fault_count = 0;
  int   live_bytes  = 0;
  logic jitter_on   = 1'b1;
  logic hold_req    = 1'b0;

  step_t directed_steps [DIRECTED_ROWS] = '{
    '{ROW_CHECKED, 16'h0000, 1'b0, '{16'h0000, 1'b1, 1'b0, 16'd1, ST_OK}},
    '{ROW_CHECKED, 16'h007f, 1'b0, '{16'h007f, 1'b1, 1'b0, 16'd2, ST_OK}},
    '{ROW_BYTE,    16'h00c2, 1'b0, '0},
    '{ROW_BYTE,    16'h00a9, 1'b0, '0},
    '{ROW_BYTE,    16'h00ef, 1'b0, '0},
    '{ROW_BYTE,    16'h00bf, 1'b0, '0},
    '{ROW_BYTE,    16'h00bf, 1'b0, '0},
    '{ROW_BYTE,    16'h00f7, 1'b0, '0},
    '{ROW_BYTE,    16'h00bf, 1'b0, '0},
    '{ROW_BYTE,    16'h00bf, 1'b0, '0},
    '{ROW_BYTE,    16'h00bf, 1'b0, '0},
    '{ROW_CHECKED, 16'h00ff, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd5, ST_BAD_LEAD}},
    '{ROW_BYTE,    16'h0080, 1'b0, '0},
    '{ROW_CHECKED, 16'h0041, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd0, ST_BAD_LEAD}},
    '{ROW_CHECKED, 16'h00e2, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd0, ST_TRUNCATED}},
    '{ROW_BYTE,    16'h00c3, 1'b0, '0},
    '{ROW_BYTE,    16'h0041, 1'b1, '0},
    '{ROW_BYTE,    16'h00e2, 1'b0, '0},
    '{ROW_BYTE,    16'h0082, 1'b1, '0},
    '{ROW_LIMIT,   16'h0000, 1'b0, '0},
    '{ROW_CHECKED, 16'h00c3, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd1, ST_TRUNCATED}},
    '{ROW_BYTE,    16'h00e2, 1'b0, '0},
    '{ROW_LIMIT,   16'hffff, 1'b0, '0},
    '{ROW_BYTE,    16'h0082, 1'b0, '0},
    '{ROW_BYTE,    16'h00ac, 1'b0, '0},
    '{ROW_BYTE,    16'h00c3, 1'b0, '0},
    '{ROW_LIMIT,   16'h0000, 1'b0, '0},
    '{ROW_BYTE,    16'h00a9, 1'b1, '0},
    '{ROW_LIMIT,   16'h0001, 1'b0, '0},
    '{ROW_CHECKED, 16'h0041, 1'b1, '{16'h0041, 1'b1, 1'b1, 16'd1, ST_OK}},
    '{ROW_BYTE,    16'h0041, 1'b0, '0},
    '{ROW_CHECKED, 16'h0042, 1'b1, '{16'h0000, 1'b0, 1'b1, 16'd1, ST_LIMIT}}
  };

  utf8_to_ucs2_stream_decoder u_top (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_byte        (in_byte),
    .in_last_byte   (in_last_byte),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_unit       (out_unit),
    .out_unit_valid (out_unit_valid),
    .out_done_res   (out_done_res),
    .out_unit_count (out_unit_count),
    .out_status     (out_status),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Advance the decoder image by one byte; returns 1 when a result word is due
  function automatic logic decode_byte(input logic [7:0] b, input logic last,
                                       output result_t word);
    logic        count_only;
    logic        emit;
    logic [15:0] unit;
    logic [2:0]  lead_len;
    logic [2:0]  rest;
    count_only = (unit_limit == 16'h0000);
    emit = 1'b0;
    unit = 16'h0000;
    casez (b)
      8'b0???????: lead_len = 3'd1;
      8'b110?????: lead_len = 3'd2;
      8'b1110????: lead_len = 3'd3;
      8'b11110???: lead_len = 3'd4;
      default:     lead_len = 3'd0;
    endcase
    rest = lead_len - 3'd1;

    if (!decoder.halted) begin
      if (decoder.bytes_left != 2'd0) begin
        // Continuation: shift in six payload bits, keep the low 16
        decoder.partial = {decoder.partial[9:0], b[5:0]};
        decoder.bytes_left = decoder.bytes_left - 2'd1;
        if (decoder.bytes_left == 2'd0) begin
          if (!count_only) begin
            emit = 1'b1;
            unit = decoder.partial;
            if (decoder.count != COUNT_MAX) decoder.count = decoder.count + 16'd1;
          end
        end else if (last) begin
          decoder.status = ST_TRUNCATED;
        end
      end else if (lead_len == 3'd0) begin
        decoder.halted = 1'b1;
        decoder.status = ST_BAD_LEAD;
      end else if (count_only) begin
        // Count the character at its lead byte
        if (decoder.count != COUNT_MAX) decoder.count = decoder.count + 16'd1;
        decoder.partial = 16'h0000;
        decoder.bytes_left = rest[1:0];
        if (last && lead_len > 3'd1) decoder.status = ST_TRUNCATED;
      end else if (decoder.count >= unit_limit) begin
        decoder.halted = 1'b1;
        decoder.status = ST_LIMIT;
      end else if (lead_len == 3'd1) begin
        emit = 1'b1;
        unit = {8'h00, b};
        if (decoder.count != COUNT_MAX) decoder.count = decoder.count + 16'd1;
      end else if (last) begin
        decoder.halted = 1'b1;
        decoder.status = ST_TRUNCATED;
      end else begin
        case (lead_len)
          3'd2:    decoder.partial = {11'h000, b[4:0]};
          3'd3:    decoder.partial = {12'h000, b[3:0]};
          default: decoder.partial = {13'h0000, b[2:0]};
        endcase
        decoder.bytes_left = rest[1:0];
      end
    end

    word.unit       = unit;
    word.unit_valid = emit;
    word.done       = last;
    word.count      = decoder.count;
    word.status     = decoder.status;
    if (last) decoder = '0;
    return emit || last;
  endfunction

  // Offer one byte, hold it until accepted, then queue its expected word
  task automatic send_byte(input logic [7:0] b, input logic last, input logic typed,
                           input result_t want);
    result_t word;
    logic    has_word;
    if (jitter_on) begin
      while ($urandom_range(99) < 32) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid     <= 1'b1;
    in_byte      <= b;
    in_last_byte <= last;
    do @(posedge clk); while (!in_ready);
    live_bytes++;
    has_word = decode_byte(b, last, word);
    if (has_word) unit_words_due.push_back(typed ? want : word);
  endtask

  // Drain the decoder, let in-flight bytes settle, then write max_units
  task automatic write_limit(input logic [15:0] value);
    in_valid <= 1'b0;
    while (unit_words_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en  <= 1'b0;
    unit_limit = value;
  endtask

  // Build one stream of mostly well-formed characters with random content
  task automatic send_stream();
    logic [7:0]  seq[$];
    logic [31:0] rnd;
    logic [31:0] cont;
    logic [7:0]  lead;
    int          chars;
    int          pick;
    int          n_cont;
    chars = $urandom_range(1, 12);
    repeat (chars) begin
      rnd = $urandom;
      pick = $urandom_range(99);
      n_cont = 0;
      if (pick < 40) begin
        lead = {1'b0, rnd[6:0]};
      end else if (pick < 62) begin
        lead = {3'b110, rnd[4:0]};
        n_cont = 1;
      end else if (pick < 80) begin
        lead = {4'b1110, rnd[3:0]};
        n_cont = 2;
      end else if (pick < 90) begin
        lead = {5'b11110, rnd[2:0]};
        n_cont = 3;
      end else if (pick < 95) begin
        lead = rnd[8] ? {2'b10, rnd[5:0]} : {5'b11111, rnd[2:0]};
      end else begin
        lead = rnd[7:0];
      end
      seq.push_back(lead);
      repeat (n_cont) begin
        cont = $urandom;
        seq.push_back(($urandom_range(9) == 0) ? cont[7:0] : {2'b10, cont[5:0]});
      end
    end
    // Cut the stream short now and then
    if ($urandom_range(99) < 12) begin
      repeat ($urandom_range(1, 2)) begin
        if (seq.size() > 1) void'(seq.pop_back());
      end
    end
    foreach (seq[i]) send_byte(seq[i], i == seq.size() - 1, 1'b0, '0);
  endtask

  // Result side: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready <= 1'b0;
        for (int k = 0; k < HOLD_CYCLES; k++) @(posedge clk);
      end
      out_ready <= !jitter_on || ($urandom_range(99) >= 32);
    end
  end

  // Check every accepted result word against the oldest expectation
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        got.unit       = out_unit;
        got.unit_valid = out_unit_valid;
        got.done       = out_done_res;
        got.count      = out_unit_count;
        got.status     = out_status;
        if (unit_words_due.size() == 0) begin
          $error("result word with nothing expected: unit %h count %0d status %0d",
                 got.unit, got.count, got.status);
          fault_count++;
        end else begin
          want = unit_words_due.pop_front();
          if (got.unit != want.unit) begin
            $error("unit: expected %h, actual %h", want.unit, got.unit);
            fault_count++;
          end
          if (got.unit_valid != want.unit_valid) begin
            $error("unit_valid: expected %b, actual %b", want.unit_valid, got.unit_valid);
            fault_count++;
          end
          if (got.done != want.done) begin
            $error("done_res: expected %b, actual %b", want.done, got.done);
            fault_count++;
          end
          if (got.count != want.count) begin
            $error("unit_count: expected %0d, actual %0d", want.count, got.count);
            fault_count++;
          end
          if (got.status != want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got.status);
            fault_count++;
          end
        end
      end
    end
  end

  initial begin
    #(10_000_000);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    int          phase;
    int          phase_end;
    int          wait_cycles;
    logic [15:0] next_limit;

    rst_n        <= 1'b0;
    in_valid     <= 1'b0;
    in_byte      <= 8'h00;
    in_last_byte <= 1'b0;
    cfg_wr_en    <= 1'b0;
    cfg_wr_data  <= 16'h0000;
    decoder    = '0;
    unit_limit = 16'hffff;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows
    foreach (directed_steps[i]) begin
      case (directed_steps[i].kind)
        ROW_LIMIT:   write_limit(directed_steps[i].value);
        ROW_CHECKED: send_byte(directed_steps[i].value[7:0], directed_steps[i].last, 1'b1,
                               directed_steps[i].want);
        default:     send_byte(directed_steps[i].value[7:0], directed_steps[i].last, 1'b0,
                               '0);
      endcase
    end

    // Random streams in phases, each under its own unit limit
    live_bytes = 0;
    phase = 0;
    while (live_bytes < RANDOM_BYTES) begin
      if (phase == 2) begin
        next_limit = 16'hffff;
      end else begin
        case ($urandom_range(4))
          0:       next_limit = 16'h0000;
          1:       next_limit = 16'hffff;
          2:       next_limit = 16'($urandom_range(1, 3));
          3:       next_limit = 16'($urandom_range(4, 24));
          default: next_limit = 16'($urandom);
        endcase
      end
      write_limit(next_limit);
      jitter_on = (phase != 1);
      if (phase == 2) hold_req = 1'b1;
      phase_end = live_bytes + PHASE_BYTES;
      while (live_bytes < phase_end) send_stream();
      phase++;
    end
    jitter_on = 1'b1;

    // Drain and wrap up
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (unit_words_due.size() != 0 && wait_cycles < DRAIN_LIMIT) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (8) @(posedge clk);
    if (unit_words_due.size() != 0) begin
      $error("%0d result words never arrived", unit_words_due.size());
      fault_count++;
    end
    if (fault_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
